// File: design/ptw_pkg.sv
package ptw_pkg;

  // Default depth of the table memory, in 64-bit words.
  localparam int unsigned TABLE_WORDS_DEF = 32768;

  // Entries in one table, and the address bits that they cover.
  localparam int unsigned TABLE_ENTRIES = 512;
  localparam int unsigned IDX_W         = 9;
  localparam int unsigned FRAME_W       = 40;
  localparam int unsigned PADDR_W       = 52;
  localparam int unsigned VADDR_W       = 48;
  localparam int unsigned ENTRY_W       = 64;

  // Input item codes (tuser).
  localparam logic OP_WRITE     = 1'b0;
  localparam logic OP_TRANSLATE = 1'b1;

  // Walk levels; a leaf level doubles as the page size code.
  localparam logic [1:0] LVL_PT   = 2'd0;
  localparam logic [1:0] LVL_PD   = 2'd1;
  localparam logic [1:0] LVL_PDPT = 2'd2;
  localparam logic [1:0] LVL_PML4 = 2'd3;

  // Cache mode codes.
  localparam logic [1:0] CACHE_WB = 2'd0;
  localparam logic [1:0] CACHE_WT = 2'd1;
  localparam logic [1:0] CACHE_UC = 2'd2;

  // Entry bit positions.
  localparam int unsigned BIT_P   = 0;
  localparam int unsigned BIT_RW  = 1;
  localparam int unsigned BIT_US  = 2;
  localparam int unsigned BIT_PWT = 3;
  localparam int unsigned BIT_PCD = 4;
  localparam int unsigned BIT_PS  = 7;
  localparam int unsigned BIT_NX  = 63;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_ISSUE,
    ST_EVAL,
    ST_DONE
  } ptw_state_e;

  typedef enum logic [1:0] {
    RES_ZERO,
    RES_BAD,
    RES_LEAF
  } ptw_res_e;

  typedef struct packed {
    logic     load;
    logic     mem_we;
    logic     mem_re;
    logic     descend;
    logic     res_load;
    ptw_res_e res_kind;
  } ptw_cmd_t;

  typedef struct packed {
    logic is_xlate;
    logic table_ok;
    logic present;
    logic leaf;
    logic out_free;
  } ptw_sts_t;

endpackage

// File: design/ptw_ram.sv
module ptw_ram #(
  parameter int unsigned Width = 64,
  parameter int unsigned Depth = 512
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(Depth)-1:0] waddr_i,
  input  logic [Width-1:0]         wdata_i,
  input  logic                     re_i,
  input  logic [$clog2(Depth)-1:0] raddr_i,
  output logic [Width-1:0]         rdata_o
);

  logic [Width-1:0] mem_q [Depth];
  logic [Width-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    // hold the last read word until the next read
    if (re_i) begin
      rdata_q <= mem_q[raddr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

// File: design/ptw_ctrl.sv
module ptw_ctrl (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              s_tvalid_i,
  output logic              s_tready_o,
  input  ptw_pkg::ptw_sts_t sts_i,
  output ptw_pkg::ptw_cmd_t cmd_o
);

  ptw_pkg::ptw_state_e state_q, state_d;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ptw_pkg::ST_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

  always_comb begin
    state_d      = state_q;
    s_tready_o   = 1'b0;
    cmd_o        = '0;
    cmd_o.res_kind = ptw_pkg::RES_ZERO;
    case (state_q)
      ptw_pkg::ST_IDLE: begin
        s_tready_o = 1'b1;
        if (s_tvalid_i) begin
          cmd_o.load = 1'b1;
          if (sts_i.is_xlate) begin
            state_d = ptw_pkg::ST_ISSUE;
          end else begin
            cmd_o.mem_we = 1'b1;
            state_d      = ptw_pkg::ST_DONE;
          end
        end
      end
      ptw_pkg::ST_ISSUE: begin
        if (!sts_i.table_ok) begin
          if (sts_i.out_free) begin
            cmd_o.res_load = 1'b1;
            cmd_o.res_kind = ptw_pkg::RES_BAD;
            state_d        = ptw_pkg::ST_IDLE;
          end
        end else begin
          cmd_o.mem_re = 1'b1;
          state_d      = ptw_pkg::ST_EVAL;
        end
      end
      ptw_pkg::ST_EVAL: begin
        if (!sts_i.present) begin
          if (sts_i.out_free) begin
            cmd_o.res_load = 1'b1;
            cmd_o.res_kind = ptw_pkg::RES_ZERO;
            state_d        = ptw_pkg::ST_IDLE;
          end
        end else if (sts_i.leaf) begin
          if (sts_i.out_free) begin
            cmd_o.res_load = 1'b1;
            cmd_o.res_kind = ptw_pkg::RES_LEAF;
            state_d        = ptw_pkg::ST_IDLE;
          end
        end else begin
          // advance to the next table
          cmd_o.descend = 1'b1;
          state_d       = ptw_pkg::ST_ISSUE;
        end
      end
      ptw_pkg::ST_DONE: begin
        if (sts_i.out_free) begin
          cmd_o.res_load = 1'b1;
          cmd_o.res_kind = ptw_pkg::RES_ZERO;
          state_d        = ptw_pkg::ST_IDLE;
        end
      end
      default: begin
        state_d = ptw_pkg::ST_IDLE;
      end
    endcase
  end

endmodule

// File: design/ptw_dp.sv
module ptw_dp #(
  parameter int unsigned TableWords = ptw_pkg::TABLE_WORDS_DEF
) (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  ptw_pkg::ptw_cmd_t             cmd_i,
  output ptw_pkg::ptw_sts_t             sts_o,
  input  logic                          cfg_we_i,
  input  logic [ptw_pkg::PADDR_W-1:0]   cfg_wdata_i,
  input  logic [127:0]                  s_tdata_i,
  input  logic                          s_tuser_i,
  input  logic                          m_tready_i,
  output logic                          m_tvalid_o,
  output logic [63:0]                   m_tdata_o
);

  localparam int unsigned AddrW     = $clog2(TableWords);
  localparam int unsigned NumTables = TableWords / ptw_pkg::TABLE_ENTRIES;

  logic [ptw_pkg::PADDR_W-1:0] root_q;
  logic [ptw_pkg::VADDR_W-1:0] va_q;
  logic [ptw_pkg::FRAME_W-1:0] frame_q;
  logic [1:0]                  lvl_q;
  logic                        valid_q;
  logic [63:0]                 out_q;

  logic [14:0]                 in_widx;
  logic [63:0]                 in_wdata;
  logic [ptw_pkg::VADDR_W-1:0] in_va;
  logic [31:0]                 widx_ext;
  logic                        wr_en;
  logic [ptw_pkg::IDX_W-1:0]   idx;
  logic [ptw_pkg::FRAME_W+ptw_pkg::IDX_W-1:0] word_addr;
  logic [ptw_pkg::ENTRY_W-1:0] entry;
  logic [ptw_pkg::PADDR_W-1:0] paddr;
  logic [1:0]                  cache;
  logic [63:0]                 res;

  assign in_widx  = s_tdata_i[14:0];
  assign in_wdata = s_tdata_i[78:15];
  assign in_va    = s_tdata_i[126:79];
  assign widx_ext = 32'(in_widx);
  assign wr_en    = cmd_i.mem_we && (widx_ext < 32'(TableWords));

  always_comb begin
    case (lvl_q)
      ptw_pkg::LVL_PML4: idx = va_q[47:39];
      ptw_pkg::LVL_PDPT: idx = va_q[38:30];
      ptw_pkg::LVL_PD:   idx = va_q[29:21];
      default:           idx = va_q[20:12];
    endcase
  end

  assign word_addr = {frame_q, idx};

  ptw_ram #(
    .Width(ptw_pkg::ENTRY_W),
    .Depth(TableWords)
  ) u_ram (
    .clk_i  (clk_i),
    .we_i   (wr_en),
    .waddr_i(widx_ext[AddrW-1:0]),
    .wdata_i(in_wdata),
    .re_i   (cmd_i.mem_re),
    .raddr_i(word_addr[AddrW-1:0]),
    .rdata_o(entry)
  );

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      root_q <= '0;
    end else if (cfg_we_i) begin
      root_q <= cfg_wdata_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.load) begin
      va_q    <= in_va;
      frame_q <= root_q[51:12];
      lvl_q   <= ptw_pkg::LVL_PML4;
    end else if (cmd_i.descend) begin
      frame_q <= entry[51:12];
      lvl_q   <= lvl_q - 2'd1;
    end
  end

  always_comb begin
    case (lvl_q)
      ptw_pkg::LVL_PDPT: paddr = {entry[51:30], va_q[29:0]};
      ptw_pkg::LVL_PD:   paddr = {entry[51:21], va_q[20:0]};
      default:           paddr = {entry[51:12], va_q[11:0]};
    endcase
    if (entry[ptw_pkg::BIT_PWT] && entry[ptw_pkg::BIT_PCD]) begin
      cache = ptw_pkg::CACHE_UC;
    end else if (entry[ptw_pkg::BIT_PWT]) begin
      cache = ptw_pkg::CACHE_WT;
    end else begin
      cache = ptw_pkg::CACHE_WB;
    end
    res = '0;
    case (cmd_i.res_kind)
      ptw_pkg::RES_BAD: begin
        res[60] = 1'b1;
      end
      ptw_pkg::RES_LEAF: begin
        res[0]     = 1'b1;
        res[52:1]  = paddr;
        res[53]    = entry[ptw_pkg::BIT_RW];
        res[54]    = !entry[ptw_pkg::BIT_NX];
        res[55]    = entry[ptw_pkg::BIT_US];
        res[57:56] = cache;
        res[59:58] = lvl_q;
      end
      default: begin
        res = '0;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else if (cmd_i.res_load) begin
      valid_q <= 1'b1;
    end else if (m_tready_i) begin
      valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.res_load) begin
      out_q <= res;
    end
  end

  assign sts_o.is_xlate = (s_tuser_i == ptw_pkg::OP_TRANSLATE);
  assign sts_o.table_ok = (frame_q < ptw_pkg::FRAME_W'(NumTables));
  assign sts_o.present  = entry[ptw_pkg::BIT_P];
  assign sts_o.leaf     = (lvl_q == ptw_pkg::LVL_PT) ||
                          ((lvl_q != ptw_pkg::LVL_PML4) && entry[ptw_pkg::BIT_PS]);
  assign sts_o.out_free = !valid_q || m_tready_i;

  assign m_tvalid_o = valid_q;
  assign m_tdata_o  = out_q;

endmodule

// File: design/four_level_page_table_walker_unit.sv
// Four-level page walker over a local table memory of TABLE_WORDS 64-bit entries. A word with
// tuser 0 stores write_data at word_index (indexes at or above TABLE_WORDS are dropped) and
// returns an all-zero result. A word with tuser 1 walks PML4, PDPT, PD and PT from the root
// register, stopping at a non-present or leaf entry, and returns one result: the word is taken,
// then each level visited gets a table bounds check and read issue, then evaluation of the
// registered read data from the single table memory read port. A table outside the memory ends
// the walk at its bounds check. Items are handled one at a time; a new word is taken while the
// previous result still waits in the output register, and a walk holds at its end until that
// register is free. Write the root register only while the block is idle.
module four_level_page_table_walker_unit #(
  parameter int unsigned TABLE_WORDS = ptw_pkg::TABLE_WORDS_DEF
) (
  input  logic         clk_i,
  input  logic         rst_ni,
  input  logic         cfg_we_i,
  input  logic [51:0]  cfg_wdata_i,
  input  logic         s_axis_tvalid,
  output logic         s_axis_tready,
  // [14:0] word_index, [78:15] write_data, [126:79] virtual_address, [127] zero
  input  logic [127:0] s_axis_tdata,
  // [0] operation
  input  logic         s_axis_tuser,
  output logic         m_axis_tvalid,
  input  logic         m_axis_tready,
  // [0] translated, [52:1] physical_address, [53] writable, [54] executable,
  // [55] user_access, [57:56] cache_mode, [59:58] size code,
  // [60] bad_table_address, [63:61] zero
  output logic [63:0]  m_axis_tdata
);

  ptw_pkg::ptw_cmd_t cmd;
  ptw_pkg::ptw_sts_t sts;

  ptw_ctrl u_ctrl (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .s_tvalid_i(s_axis_tvalid),
    .s_tready_o(s_axis_tready),
    .sts_i     (sts),
    .cmd_o     (cmd)
  );

  ptw_dp #(
    .TableWords(TABLE_WORDS)
  ) u_dp (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .cmd_i      (cmd),
    .sts_o      (sts),
    .cfg_we_i   (cfg_we_i),
    .cfg_wdata_i(cfg_wdata_i),
    .s_tdata_i  (s_axis_tdata),
    .s_tuser_i  (s_axis_tuser),
    .m_tready_i (m_axis_tready),
    .m_tvalid_o (m_axis_tvalid),
    .m_tdata_o  (m_axis_tdata)
  );

  // one item in flight: intake closes right after a word is taken
  a_intake_closes: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (s_axis_tvalid && s_axis_tready) |=> !s_axis_tready)
    else $error("input taken again while an item is in flight");

  // a failed table bound clears every other field
  a_bad_is_clean: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (m_axis_tvalid && m_axis_tdata[60]) |-> (m_axis_tdata[59:0] == 60'd0))
    else $error("bad table result carries leaf fields");

  // leaf results use only defined size and cache codes
  a_leaf_codes: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (m_axis_tvalid && m_axis_tdata[0]) |->
      ((m_axis_tdata[59:58] != 2'd3) && (m_axis_tdata[57:56] != 2'd3)))
    else $error("leaf result with undefined code");

endmodule
